// File: rtl/mfbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfbr_pkg;

  localparam int unsigned DefaultFifoDepth = 16;
  localparam int unsigned ByteBits         = 8;
  localparam int unsigned CountBits        = 6;
  localparam int unsigned ValueBits        = 32;
  localparam int unsigned MaxBits          = 32;

  localparam logic KindPush = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    push_we;   // store the byte, advance write pointer
    logic    rd_start;  // load bit count, clear accumulator
    logic    step;      // consume bits from the head byte
    logic    flush;     // drop every held bit
    logic    out_load;  // load the result register
    logic    out_acc;   // result value from the accumulator as updated by this step, else zero
    status_e out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;       // no free slot for a push
    logic short_rd;   // fewer bits held than requested
    logic last_step;  // this step finishes the read
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/mfbr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mfbr_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic                              kind_i,
  input  wire logic [mfbr_pkg::CountBits-1:0]    bit_count_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      mfbr_pkg::cmd_t                    cmd_o,
  input  wire mfbr_pkg::stat_t                   stat_i
);
  import mfbr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_STEP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{push_we: 1'b0, rd_start: 1'b0, step: 1'b0, flush: 1'b0,
                out_load: 1'b0, out_acc: 1'b0, out_status: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KindPush) begin
            cmd_o.out_load = 1'b1;
            if (stat_i.full) begin
              cmd_o.out_status = ST_FULL;
            end else begin
              cmd_o.push_we = 1'b1;
            end
          end else if (bit_count_i == '0) begin
            cmd_o.out_load = 1'b1;
          end else if (bit_count_i > CountBits'(MaxBits)) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_BOUNDS;
          end else if (stat_i.short_rd) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.flush      = 1'b1;
            cmd_o.out_status = ST_SHORT;
          end else begin
            cmd_o.rd_start = 1'b1;
            state_d        = S_STEP;
          end
        end
      end
      S_STEP: begin
        // the last step waits until the result register can take it
        if (!stat_i.last_step || out_free) begin
          cmd_o.step = 1'b1;
          if (stat_i.last_step) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_acc  = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mfbr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mfbr_datapath #(
  parameter int unsigned FIFO_DEPTH = mfbr_pkg::DefaultFifoDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [mfbr_pkg::ByteBits-1:0]     data_byte_i,
  input  wire logic [mfbr_pkg::CountBits-1:0]    bit_count_i,
  input  wire mfbr_pkg::cmd_t                    cmd_i,
  output      mfbr_pkg::stat_t                   stat_o,
  output      logic [mfbr_pkg::ValueBits-1:0]    value_o,
  output      logic [1:0]                        status_o
);
  import mfbr_pkg::*;

  localparam int unsigned IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AW = CW + 3;

  logic [ByteBits-1:0]  mem [FIFO_DEPTH];
  logic [ByteBits-1:0]  rd_data_q;

  logic [IW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [IW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [2:0]           bit_off_q, bit_off_d;
  logic [CountBits-1:0] rem_q, rem_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic [ValueBits-1:0] value_q;
  status_e              status_q;

  logic [AW-1:0]        avail;
  logic [3:0]           hd_bits;
  logic [3:0]           take;
  logic [ByteBits-1:0]  byte_al;
  logic [ByteBits-1:0]  piece;
  logic [ValueBits-1:0] acc_step;
  logic [3:0]           off_sum;
  logic                 drop;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] p);
    return (p == IW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // bits held, counting only the unconsumed part of the head byte
  assign avail = (fill_q == '0) ? '0 : ({fill_q, 3'b000} - AW'(bit_off_q));

  // one step takes what is left in the head byte, capped by the bits still wanted
  assign hd_bits  = 4'd8 - {1'b0, bit_off_q};
  assign take     = ({2'b00, hd_bits} < rem_q) ? hd_bits : rem_q[3:0];
  assign byte_al  = rd_data_q << bit_off_q;
  assign piece    = byte_al >> (4'd8 - take);
  assign acc_step = (acc_q << take) | {{(ValueBits - ByteBits){1'b0}}, piece};
  assign off_sum  = {1'b0, bit_off_q} + take;
  assign drop     = off_sum[3];

  assign stat_o.full      = (fill_q == CW'(FIFO_DEPTH));
  assign stat_o.short_rd  = (avail < AW'(bit_count_i));
  assign stat_o.last_step = (rem_q <= {2'b00, hd_bits});

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    fill_d    = fill_q;
    bit_off_d = bit_off_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    if (cmd_i.push_we) begin
      wr_ptr_d = next_slot(wr_ptr_q);
      fill_d   = fill_q + 1'b1;
    end
    if (cmd_i.flush) begin
      rd_ptr_d  = wr_ptr_q;
      fill_d    = '0;
      bit_off_d = '0;
    end
    if (cmd_i.rd_start) begin
      rem_d = bit_count_i;
      acc_d = '0;
    end
    if (cmd_i.step) begin
      rem_d     = rem_q - {2'b00, take};
      acc_d     = acc_step;
      bit_off_d = off_sum[2:0];
      if (drop) begin
        rd_ptr_d = next_slot(rd_ptr_q);
        fill_d   = fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      fill_q    <= '0;
      bit_off_q <= '0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      fill_q    <= fill_d;
      bit_off_q <= bit_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    if (cmd_i.out_load) begin
      value_q  <= cmd_i.out_acc ? acc_step : '0;
      status_q <= cmd_i.out_status;
    end
  end

  // byte store: the read port follows the next head pointer so the head byte is ready
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_we) begin
      mem[wr_ptr_q] <= data_byte_i;
    end
    rd_data_q <= mem[rd_ptr_d];
  end

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// File: rtl/msb_first_bit_reader.sv
`timescale 1ns / 1ps
`default_nettype none

// msb first bit reader: a transaction either pushes one byte into a byte fifo
// (kind 0) or reads bit_count bits from it (kind 1), oldest byte first and
// starting at its bit 7; each transaction returns exactly one result with the
// bits right-aligned in value_o and a status (ok, not enough data, count out of
// bounds, fifo full). a push, a zero-bit read, a read above 32 bits and a short
// read finish in the accept cycle, which loads the result register directly.
// a good read of n bits is accepted, then takes one step for each of the k (1 to 5)
// stored bytes the field touches: the byte store has one read port and the bit
// extractor consumes at most one byte per cycle. the block works on one
// transaction at a time; a finished result waits in the output register and a
// new transaction is taken in the same cycle the old result leaves.

module msb_first_bit_reader #(
  parameter int unsigned FIFO_DEPTH = mfbr_pkg::DefaultFifoDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input transactions
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic                              kind_i,
  input  wire logic [mfbr_pkg::ByteBits-1:0]     data_byte_i,
  input  wire logic [mfbr_pkg::CountBits-1:0]    bit_count_i,
  // result transactions
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [mfbr_pkg::ValueBits-1:0]    value_o,
  output      logic [1:0]                        status_o
);
  import mfbr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decodes a transaction, walks a read one byte per cycle, unless held
  mfbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .bit_count_i (bit_count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // byte store, pointers, bit extractor and result register
  mfbr_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .bit_count_i (bit_count_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// File: sim/msb_first_bit_reader_tb.sv
`timescale 1ns / 1ps

module msb_first_bit_reader_tb;

  import mfbr_pkg::*;

  localparam int unsigned FifoDepth  = DefaultFifoDepth;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned PhaseItems = 400;
  localparam int unsigned SettleCycles = 16;

  // one result transaction as the block should return it
  typedef struct {
    logic [ValueBits-1:0] value;
    status_e              status;
  } field_result_t;

  // directed stimulus row; fixed rows carry their result typed in
  typedef struct {
    logic                 kind;
    logic [ByteBits-1:0]  data;
    logic [CountBits-1:0] count;
    bit                   fixed;
    logic [ValueBits-1:0] value;
    status_e              status;
  } script_row_t;

  localparam int unsigned NumRows = 22;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 kind_in   = KindPush;
  logic [ByteBits-1:0]  data_in   = '0;
  logic [CountBits-1:0] count_in  = '0;
  logic                 out_stall = 1'b0;
  wire                  in_stall;
  wire                  out_valid;
  wire [ValueBits-1:0]  value_out;
  wire [1:0]            status_out;

  // bit fifo model, mirrors the byte store and the head position
  logic [ByteBits-1:0] fifo_bytes [FifoDepth];
  int unsigned held_bytes = 0;
  int unsigned head_slot  = 0;
  int unsigned tail_slot  = 0;
  int unsigned head_bit   = 0;

  field_result_t pending_fields [$];

  int unsigned mismatch_count     = 0;
  int unsigned cycle_count        = 0;
  int unsigned items_sent         = 0;
  int unsigned sender_gap_pct     = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holds_requested    = 0;
  int unsigned holds_served       = 0;
  int unsigned hold_left          = 0;

  script_row_t script [NumRows] = '{
    // empty fifo: zero-bit read, short read, out-of-bounds counts
    '{KindRead, 8'h00, 6'd0,  1'b1, 32'h0,  ST_OK},
    '{KindRead, 8'h00, 6'd1,  1'b1, 32'h0,  ST_SHORT},
    '{KindRead, 8'h00, 6'd33, 1'b1, 32'h0,  ST_BOUNDS},
    '{KindRead, 8'hFF, 6'd63, 1'b1, 32'h0,  ST_BOUNDS},
    // one full byte in and out
    '{KindPush, 8'hFF, 6'd0,  1'b1, 32'h0,  ST_OK},
    '{KindRead, 8'h00, 6'd8,  1'b1, 32'hFF, ST_OK},
    // count ignored on a push, then a widest read that runs short
    '{KindPush, 8'h00, 6'd63, 1'b1, 32'h0,  ST_OK},
    '{KindRead, 8'h00, 6'd32, 1'b1, 32'h0,  ST_SHORT},
    '{KindRead, 8'h00, 6'd1,  1'b1, 32'h0,  ST_SHORT},
    // five bytes, a 3-bit read, then a 32-bit field that touches all five
    '{KindPush, 8'hA5, 6'd0,  1'b0, 32'h0,  ST_OK},
    '{KindPush, 8'h3C, 6'd21, 1'b0, 32'h0,  ST_OK},
    '{KindPush, 8'h80, 6'd0,  1'b0, 32'h0,  ST_OK},
    '{KindPush, 8'h01, 6'd42, 1'b0, 32'h0,  ST_OK},
    '{KindPush, 8'h7E, 6'd0,  1'b0, 32'h0,  ST_OK},
    '{KindRead, 8'h00, 6'd3,  1'b0, 32'h0,  ST_OK},
    '{KindRead, 8'hFF, 6'd32, 1'b0, 32'h0,  ST_OK},
    '{KindRead, 8'hFF, 6'd0,  1'b1, 32'h0,  ST_OK},
    '{KindRead, 8'h00, 6'd2,  1'b0, 32'h0,  ST_OK},
    '{KindRead, 8'h00, 6'd3,  1'b0, 32'h0,  ST_OK},
    // exactly drained, so one more bit is short
    '{KindRead, 8'h00, 6'd1,  1'b1, 32'h0,  ST_SHORT},
    '{KindPush, 8'h55, 6'd42, 1'b1, 32'h0,  ST_OK},
    '{KindRead, 8'h2A, 6'd32, 1'b1, 32'h0,  ST_SHORT}
  };

  msb_first_bit_reader #(
    .FIFO_DEPTH(FifoDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .kind_i     (kind_in),
    .data_byte_i(data_in),
    .bit_count_i(count_in),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .value_o    (value_out),
    .status_o   (status_out)
  );

  always #1 clk_i = ~clk_i;

  // bits still held in the model fifo
  function automatic int unsigned bits_held();
    return (held_bytes == 0) ? 0 : held_bytes * ByteBits - head_bit;
  endfunction

  // applies one transaction to the model and returns the field it yields
  function automatic void take_bits(input logic kind, input logic [ByteBits-1:0] data,
                                    input logic [CountBits-1:0] count,
                                    output logic [ValueBits-1:0] value,
                                    output status_e status);
    value  = '0;
    status = ST_OK;
    if (kind == KindPush) begin
      if (held_bytes >= FifoDepth) begin
        status = ST_FULL;
      end else begin
        fifo_bytes[tail_slot] = data;
        tail_slot  = (tail_slot == FifoDepth - 1) ? 0 : tail_slot + 1;
        held_bytes = held_bytes + 1;
      end
    end else if (count == 0) begin
      // zero-bit read consumes nothing
    end else if (count > MaxBits) begin
      status = ST_BOUNDS;
    end else if (bits_held() < count) begin
      // short read throws away every held bit
      held_bytes = 0;
      head_bit   = 0;
      head_slot  = tail_slot;
      status     = ST_SHORT;
    end else begin
      for (int unsigned i = 0; i < count; i++) begin
        value    = {value[ValueBits-2:0], fifo_bytes[head_slot][ByteBits-1-head_bit]};
        head_bit = head_bit + 1;
        if (head_bit == ByteBits) begin
          head_bit   = 0;
          head_slot  = (head_slot == FifoDepth - 1) ? 0 : head_slot + 1;
          held_bytes = held_bytes - 1;
        end
      end
    end
  endfunction

  // offers one transaction from a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic kind, input logic [ByteBits-1:0] data,
                           input logic [CountBits-1:0] count, input bit fixed,
                           input logic [ValueBits-1:0] fixed_value,
                           input status_e fixed_status);
    field_result_t predicted;
    while ($urandom_range(99, 0) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    kind_in  <= kind;
    data_in  <= data;
    count_in <= count;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    take_bits(kind, data, count, predicted.value, predicted.status);
    if (fixed) begin
      predicted.value  = fixed_value;
      predicted.status = fixed_status;
    end
    pending_fields.push_back(predicted);
    items_sent = items_sent + 1;
    @(negedge clk_i);
  endtask

  // sender goes quiet until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly push bursts and reads that fit the held bits, the rest noise
  task automatic run_random(input int unsigned quota, input bit with_hold);
    int unsigned first_item;
    int unsigned pick;
    int unsigned burst;
    int unsigned widest;
    bit          hold_asked;
    first_item = items_sent;
    hold_asked = 1'b0;
    while (items_sent - first_item < quota) begin
      if (with_hold && !hold_asked && items_sent - first_item >= quota / 4) begin
        holds_requested = holds_requested + 1;
        hold_asked = 1'b1;
      end
      pick = $urandom_range(99, 0);
      if (pick < 40 || bits_held() == 0 && pick < 85) begin
        // occasional long bursts run into a full fifo
        burst = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 1);
        repeat (burst) begin
          send_item(KindPush, ByteBits'($urandom_range(255, 0)),
                    CountBits'($urandom_range(63, 0)), 1'b0, '0, ST_OK);
        end
      end else if (pick < 85) begin
        burst = $urandom_range(4, 1);
        while (burst != 0 && bits_held() != 0) begin
          widest = (bits_held() < MaxBits) ? bits_held() : MaxBits;
          send_item(KindRead, ByteBits'($urandom_range(255, 0)),
                    CountBits'(($urandom_range(3, 0) == 0) ? widest
                                                           : $urandom_range(widest, 1)),
                    1'b0, '0, ST_OK);
          burst = burst - 1;
        end
      end else begin
        send_item(1'($urandom_range(1, 0)), ByteBits'($urandom_range(255, 0)),
                  CountBits'($urandom_range(63, 0)), 1'b0, '0, ST_OK);
      end
    end
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left == 0 && holds_served != holds_requested) begin
      holds_served = holds_served + 1;
      hold_left    = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    field_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: result with none expected: value %h status %0d",
                 $time, value_out, status_out);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_fields.pop_front();
        if (value_out !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, value_out);
          mismatch_count = mismatch_count + 1;
        end
        if (status_out !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_out);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("msb_first_bit_reader regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    sender_gap_pct     = 27;
    receiver_stall_pct = 68;
    foreach (script[i]) begin
      send_item(script[i].kind, script[i].data, script[i].count,
                script[i].fixed, script[i].value, script[i].status);
    end
    run_random(PhaseItems, 1'b0);
    drain();

    sender_gap_pct     = 68;
    receiver_stall_pct = 27;
    run_random(PhaseItems, 1'b0);
    drain();

    // no idling; a long receiver hold-off backs up the input a quarter of the way in
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    run_random(PhaseItems, 1'b1);
    drain();

    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("msb_first_bit_reader regression: pass");
    end else begin
      $display("msb_first_bit_reader regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mfbr_pkg.sv
rtl/mfbr_ctrl.sv
rtl/mfbr_datapath.sv
rtl/msb_first_bit_reader.sv
sim/msb_first_bit_reader_tb.sv
